// ===== sv/ifr_pkg.sv =====
package ifr_pkg;

    localparam int TICK_W = 10;
    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam int PADDR_W = 4;

    localparam logic [3:0] MASTER_BITS = 4'd12;
    localparam logic [3:0] SLAVE_BITS  = 4'd12;
    localparam logic [3:0] CTRL_BITS   = 4'd4;
    localparam logic [3:0] LEN_BITS    = 4'd8;
    localparam logic [3:0] DATA_BITS   = 4'd8;

    // register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_BIT_ZERO_MIN   = 2'd1;
    localparam logic [1:0] REG_START_MIN      = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH     = 2'd3;

    localparam logic [11:0] RST_DEVICE_ADDRESS = 12'd0;
    localparam logic [9:0]  RST_BIT_ZERO_MIN   = 10'd26;
    localparam logic [9:0]  RST_START_MIN      = 10'd160;
    localparam logic [7:0]  RST_MAX_LENGTH     = 8'd32;

    // result kinds
    localparam logic [2:0] KIND_ACK    = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_SHORT_START   = 3'd0;
    localparam logic [2:0] ERR_MASTER_PARITY = 3'd1;
    localparam logic [2:0] ERR_SLAVE_PARITY  = 3'd2;
    localparam logic [2:0] ERR_CTRL_PARITY   = 3'd3;
    localparam logic [2:0] ERR_LEN_PARITY    = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG      = 3'd5;
    localparam logic [2:0] ERR_DATA_PARITY   = 3'd6;

    typedef enum logic [15:0] {
        PH_WAIT     = 16'h0001,
        PH_BCAST    = 16'h0002,
        PH_MASTER   = 16'h0004,
        PH_MASTER_P = 16'h0008,
        PH_SLAVE    = 16'h0010,
        PH_SLAVE_P  = 16'h0020,
        PH_SLAVE_A  = 16'h0040,
        PH_CTRL     = 16'h0080,
        PH_CTRL_P   = 16'h0100,
        PH_CTRL_A   = 16'h0200,
        PH_LEN      = 16'h0400,
        PH_LEN_P    = 16'h0800,
        PH_LEN_A    = 16'h1000,
        PH_DATA     = 16'h2000,
        PH_DATA_P   = 16'h4000,
        PH_DATA_A   = 16'h8000
    } phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [TICK_W-1:0] bit_zero_min;
        logic [TICK_W-1:0] start_min;
        logic [BYTE_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic              broadcast;
        logic [ADDR_W-1:0] master_address;
        logic [ADDR_W-1:0] slave_address;
        logic [BYTE_W-1:0] data_length;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [2:0]        error_code;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    // fields not belonging to a kind read as zero
    function automatic result_t make_result(
        input logic [2:0]        kind,
        input logic [2:0]        code,
        input logic [BYTE_W-1:0] dbyte,
        input logic [BYTE_W-1:0] idx,
        input logic              bcast,
        input logic [ADDR_W-1:0] master,
        input logic [ADDR_W-1:0] slave,
        input logic [BYTE_W-1:0] len
    );
        result_t r;
        logic    hdr;
        hdr = (kind == KIND_HEADER) || (kind == KIND_DATA) || (kind == KIND_DONE);
        r.kind           = kind;
        r.broadcast      = hdr ? bcast : 1'b0;
        r.master_address = hdr ? master : '0;
        r.slave_address  = hdr ? slave : '0;
        r.data_length    = hdr ? len : '0;
        r.data_byte      = (kind == KIND_DATA) ? dbyte : '0;
        r.byte_index     = (kind == KIND_DATA) ? idx : '0;
        r.error_code     = (kind == KIND_ERROR) ? code : '0;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/ifr_regs.sv =====
module ifr_regs
    import ifr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= RST_DEVICE_ADDRESS;
            cfg_reg.bit_zero_min   <= RST_BIT_ZERO_MIN;
            cfg_reg.start_min      <= RST_START_MIN;
            cfg_reg.max_length     <= RST_MAX_LENGTH;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DEVICE_ADDRESS: cfg_reg.device_address <= pwdata[ADDR_W-1:0];
                REG_BIT_ZERO_MIN:   cfg_reg.bit_zero_min   <= pwdata[TICK_W-1:0];
                REG_START_MIN:      cfg_reg.start_min      <= pwdata[TICK_W-1:0];
                REG_MAX_LENGTH:     cfg_reg.max_length     <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEVICE_ADDRESS: prdata = {20'd0, cfg_reg.device_address};
            REG_BIT_ZERO_MIN:   prdata = {22'd0, cfg_reg.bit_zero_min};
            REG_START_MIN:      prdata = {22'd0, cfg_reg.start_min};
            REG_MAX_LENGTH:     prdata = {24'd0, cfg_reg.max_length};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== sv/ifr_decoder.sv =====
module ifr_decoder
    import ifr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [TICK_W-1:0] high_ticks,
    input  cfg_t              cfg,
    output push_t             push
);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [ADDR_W-1:0] shift_reg, shift_next;
    logic              parity_reg, parity_next;
    logic              to_me_reg, to_me_next;
    logic              bcast_reg, bcast_next;
    logic [ADDR_W-1:0] master_reg, master_next;
    logic [ADDR_W-1:0] slave_reg, slave_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] byte_cnt_reg, byte_cnt_next;

    logic              bit_val;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ADDR_W-1:0] shift_inc;
    logic              parity_inc;
    logic              parity_ok;
    logic [BYTE_W:0]   byte_cnt_plus;
    logic              v0, v1;
    result_t           r0, r1;

    assign bit_val       = (high_ticks < cfg.bit_zero_min);
    assign cnt_inc       = bit_count_reg + 1'b1;
    assign shift_inc     = {shift_reg[ADDR_W-2:0], bit_val};
    assign parity_inc    = parity_reg ^ bit_val;
    assign parity_ok     = (bit_val == parity_reg);
    assign byte_cnt_plus = {1'b0, byte_cnt_reg} + 1'b1;

    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        parity_next    = parity_reg;
        to_me_next     = to_me_reg;
        bcast_next     = bcast_reg;
        master_next    = master_reg;
        slave_next     = slave_reg;
        length_next    = length_reg;
        byte_cnt_next  = byte_cnt_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        r0 = make_result(KIND_ACK, ERR_SHORT_START, '0, '0, 1'b0, '0, '0, '0);
        r1 = r0;
        case (phase_reg)
            PH_WAIT: begin
                if (high_ticks < cfg.start_min) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_SHORT_START, '0, '0,
                                     1'b0, '0, '0, '0);
                end else begin
                    phase_next = PH_BCAST;
                end
            end
            PH_BCAST: begin
                bcast_next     = bit_val;
                bit_count_next = '0;
                shift_next     = '0;
                parity_next    = 1'b0;
                phase_next     = PH_MASTER;
            end
            PH_MASTER: begin
                bit_count_next = cnt_inc;
                shift_next     = shift_inc;
                parity_next    = parity_inc;
                if (cnt_inc >= MASTER_BITS) begin
                    master_next = shift_inc;
                    phase_next  = PH_MASTER_P;
                end
            end
            PH_MASTER_P: begin
                if (!parity_ok) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_MASTER_PARITY, '0, '0,
                                     1'b0, '0, '0, '0);
                    phase_next = PH_WAIT;
                end else begin
                    bit_count_next = '0;
                    shift_next     = '0;
                    parity_next    = 1'b0;
                    phase_next     = PH_SLAVE;
                end
            end
            PH_SLAVE: begin
                bit_count_next = cnt_inc;
                shift_next     = shift_inc;
                parity_next    = parity_inc;
                if (cnt_inc >= SLAVE_BITS) begin
                    slave_next = shift_inc;
                    phase_next = PH_SLAVE_P;
                end
            end
            PH_SLAVE_P: begin
                if (!parity_ok) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_SLAVE_PARITY, '0, '0,
                                     1'b0, '0, '0, '0);
                    phase_next = PH_WAIT;
                end else begin
                    to_me_next = (slave_reg == cfg.device_address);
                    v0         = (slave_reg == cfg.device_address);
                    phase_next = PH_SLAVE_A;
                end
            end
            PH_SLAVE_A: begin
                bit_count_next = '0;
                shift_next     = '0;
                parity_next    = 1'b0;
                phase_next     = PH_CTRL;
            end
            PH_CTRL: begin
                bit_count_next = cnt_inc;
                shift_next     = shift_inc;
                parity_next    = parity_inc;
                if (cnt_inc >= CTRL_BITS) begin
                    phase_next = PH_CTRL_P;
                end
            end
            PH_CTRL_P: begin
                if (!parity_ok) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_CTRL_PARITY, '0, '0,
                                     1'b0, '0, '0, '0);
                    phase_next = PH_WAIT;
                end else begin
                    v0         = to_me_reg;
                    phase_next = PH_CTRL_A;
                end
            end
            PH_CTRL_A: begin
                bit_count_next = '0;
                shift_next     = '0;
                parity_next    = 1'b0;
                phase_next     = PH_LEN;
            end
            PH_LEN: begin
                bit_count_next = cnt_inc;
                shift_next     = shift_inc;
                parity_next    = parity_inc;
                if (cnt_inc >= LEN_BITS) begin
                    length_next = shift_inc[BYTE_W-1:0];
                    phase_next  = PH_LEN_P;
                end
            end
            PH_LEN_P: begin
                if (!parity_ok) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_LEN_PARITY, '0, '0,
                                     1'b0, '0, '0, '0);
                    phase_next = PH_WAIT;
                end else begin
                    // header first, then the ack request
                    v0 = 1'b1;
                    r0 = make_result(KIND_HEADER, ERR_SHORT_START, '0, '0,
                                     bcast_reg, master_reg, slave_reg, length_reg);
                    v1 = to_me_reg;
                    phase_next = PH_LEN_A;
                end
            end
            PH_LEN_A: begin
                if (length_reg > cfg.max_length) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_TOO_LONG, '0, '0,
                                     1'b0, '0, '0, '0);
                    phase_next = PH_WAIT;
                end else if (length_reg == '0) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_DONE, ERR_SHORT_START, '0, '0,
                                     bcast_reg, master_reg, slave_reg, length_reg);
                    phase_next = PH_WAIT;
                end else begin
                    byte_cnt_next  = '0;
                    bit_count_next = '0;
                    shift_next     = '0;
                    parity_next    = 1'b0;
                    phase_next     = PH_DATA;
                end
            end
            PH_DATA: begin
                bit_count_next = cnt_inc;
                shift_next     = shift_inc;
                parity_next    = parity_inc;
                if (cnt_inc >= DATA_BITS) begin
                    phase_next = PH_DATA_P;
                end
            end
            PH_DATA_P: begin
                if (!parity_ok) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_ERROR, ERR_DATA_PARITY, '0, '0,
                                     1'b0, '0, '0, '0);
                    phase_next = PH_WAIT;
                end else begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_DATA, ERR_SHORT_START,
                                     shift_reg[BYTE_W-1:0], byte_cnt_reg,
                                     bcast_reg, master_reg, slave_reg, length_reg);
                    v1 = to_me_reg;
                    phase_next = PH_DATA_A;
                end
            end
            PH_DATA_A: begin
                if (byte_cnt_plus >= {1'b0, length_reg}) begin
                    v0 = 1'b1;
                    r0 = make_result(KIND_DONE, ERR_SHORT_START, '0, '0,
                                     bcast_reg, master_reg, slave_reg, length_reg);
                    phase_next = PH_WAIT;
                end else begin
                    byte_cnt_next  = byte_cnt_plus[BYTE_W-1:0];
                    bit_count_next = '0;
                    shift_next     = '0;
                    parity_next    = 1'b0;
                    phase_next     = PH_DATA;
                end
            end
            default: begin
                phase_next = PH_WAIT;
            end
        endcase
        r0.last = !v1;
        r1.last = 1'b1;
    end

    assign push.v0 = in_fire & v0;
    assign push.v1 = in_fire & v1;
    assign push.r0 = r0;
    assign push.r1 = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            parity_reg    <= 1'b0;
            to_me_reg     <= 1'b0;
            bcast_reg     <= 1'b0;
            master_reg    <= '0;
            slave_reg     <= '0;
            length_reg    <= '0;
            byte_cnt_reg  <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            parity_reg    <= parity_next;
            to_me_reg     <= to_me_next;
            bcast_reg     <= bcast_next;
            master_reg    <= master_next;
            slave_reg     <= slave_next;
            length_reg    <= length_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

endmodule

// ===== sv/ifr_out_queue.sv =====
module ifr_out_queue
    import ifr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_plus;
    logic [QCNT_W-1:0]  n_push;
    logic               pop;

    assign out_valid   = (count_reg != '0);
    assign out_word    = entry_reg[rd_ptr_reg];
    // two free entries cover the worst case of one incoming word
    assign room        = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop         = out_valid & out_ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;
    assign n_push      = QCNT_W'(push.v0) + QCNT_W'(push.v1);

    assign wr_ptr_next = wr_ptr_reg + n_push[QPTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + n_push - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            entry_reg[wr_ptr_plus] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/iebus_frame_receiver.sv =====
// a bus-bit word's results are written into the result queue at the edge that accepts it
// throughput: one bit word per cycle while the 4-entry result queue has room; the queue
//   takes a word while at least two entries are free
// a word that yields two results puts them on the output one after the other
// reset: synchronous active-low aresetn, waiting for a start bit, registers at defaults
module iebus_frame_receiver
    import ifr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [TICK_W-1:0]  s_high_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_result_kind,
    output logic               m_broadcast,
    output logic [ADDR_W-1:0]  m_master_address,
    output logic [ADDR_W-1:0]  m_slave_address,
    output logic [BYTE_W-1:0]  m_data_length,
    output logic [BYTE_W-1:0]  m_data_byte,
    output logic [BYTE_W-1:0]  m_byte_index,
    output logic [2:0]         m_error_code,
    output logic               m_last
);

    cfg_t    cfg;
    push_t   push;
    logic    in_fire;
    logic    room;
    result_t out_word;

    assign s_ready = room;
    assign in_fire = s_valid & room;

    ifr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifr_decoder u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .high_ticks (s_high_ticks),
        .cfg        (cfg),
        .push       (push)
    );

    ifr_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_result_kind    = out_word.kind;
    assign m_broadcast      = out_word.broadcast;
    assign m_master_address = out_word.master_address;
    assign m_slave_address  = out_word.slave_address;
    assign m_data_length    = out_word.data_length;
    assign m_data_byte      = out_word.data_byte;
    assign m_byte_index     = out_word.byte_index;
    assign m_error_code     = out_word.error_code;
    assign m_last           = out_word.last;

endmodule
